>>> rtl/core/gost_pkg.sv
// Shared types, constants and round function for the GOST block cipher core.
`timescale 1ns / 1ps

package gost_pkg;

   localparam int WORD_W     = 32;
   localparam int BLOCK_W    = 2 * WORD_W;
   localparam int NUM_ROUNDS = 32;
   localparam int NUM_KEYS   = 8;
   localparam int ROT_AMT    = 11;
   localparam int CSR_IDX_W  = 3;

   // register indexes on the csr port
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_01    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_23    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_45    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_67    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 3'd4;

   // key word used by each round in encrypt order, zero based (0..7 x3, 7..0)
   localparam logic [2:0] KEY_SEL [0:NUM_ROUNDS-1] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
   };

   // S1 .. S8; nibble i of the sum goes through entry 7-i
   localparam logic [3:0] SBOX [0:7][0:15] = '{
      '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
        4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
      '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
        4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
      '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
        4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
      '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
        4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
      '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
        4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
      '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
        4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
        4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
      '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
        4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
   };

   typedef logic [NUM_ROUNDS-1:0][WORD_W-1:0] rkey_array_type;

   typedef struct packed {
      logic               valid;
      logic [BLOCK_W-1:0] block;
   } stage_type;

   // add key, substitute nibbles, rotate left by 11
   function automatic logic [WORD_W-1:0] round_fn(input logic [WORD_W-1:0] half,
                                                  input logic [WORD_W-1:0] rkey);
      logic [WORD_W-1:0] t;
      logic [WORD_W-1:0] s;
      t = half + rkey;
      s = '0;
      for (int i = 0; i < 8; i++) begin
         s[4*i +: 4] = SBOX[7-i][t[4*i +: 4]];
      end
      return {s[WORD_W-ROT_AMT-1:0], s[WORD_W-1:WORD_W-ROT_AMT]};
   endfunction

endpackage

>>> rtl/core/gost_key_sched.sv
// Key and direction registers and per-round key selection.
`timescale 1ns / 1ps

module gost_key_sched (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_we,
   input  logic [gost_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gost_pkg::BLOCK_W-1:0]   csr_data,
   output gost_pkg::rkey_array_type    rkeys
);
   import gost_pkg::*;

   logic [WORD_W-1:0] key_ff [0:NUM_KEYS-1];
   logic              dir_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_KEYS; i++) key_ff[i] <= '0;
         dir_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_KEY_01: begin
               key_ff[0] <= csr_data[WORD_W-1:0];
               key_ff[1] <= csr_data[BLOCK_W-1:WORD_W];
            end
            CSR_KEY_23: begin
               key_ff[2] <= csr_data[WORD_W-1:0];
               key_ff[3] <= csr_data[BLOCK_W-1:WORD_W];
            end
            CSR_KEY_45: begin
               key_ff[4] <= csr_data[WORD_W-1:0];
               key_ff[5] <= csr_data[BLOCK_W-1:WORD_W];
            end
            CSR_KEY_67: begin
               key_ff[6] <= csr_data[WORD_W-1:0];
               key_ff[7] <= csr_data[BLOCK_W-1:WORD_W];
            end
            CSR_DIRECTION: dir_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // decrypt walks the schedule backwards
   always_comb begin
      for (int k = 0; k < NUM_ROUNDS; k++) begin
         rkeys[k] = dir_ff ? key_ff[KEY_SEL[NUM_ROUNDS-1-k]] : key_ff[KEY_SEL[k]];
      end
   end

endmodule

>>> rtl/core/gost_round.sv
// One Feistel round followed by its pipeline register.
`timescale 1ns / 1ps

module gost_round (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  gost_pkg::stage_type        stage_in,
   input  logic [gost_pkg::WORD_W-1:0] rkey,
   output gost_pkg::stage_type        stage_out
);
   import gost_pkg::*;

   logic               valid_ff;
   logic [BLOCK_W-1:0] block_ff;
   logic [BLOCK_W-1:0] block_in;
   logic [WORD_W-1:0]  left;
   logic [WORD_W-1:0]  right;

   assign left  = stage_in.block[BLOCK_W-1:WORD_W];
   assign right = stage_in.block[WORD_W-1:0];
   // new left is old right, new right is left ^ F(right)
   assign block_in = {right, left ^ round_fn(right, rkey)};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= stage_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         block_ff <= block_in;
      end
   end

   assign stage_out.valid = valid_ff;
   assign stage_out.block = block_ff;

endmodule

>>> rtl/core/gost_block_cipher_ecb_top.sv
// Top level: GOST 28147-89 ECB cipher, 32 round stages plus output and skid registers.
// Path: a word accepted on the input passes one register per round, then the output
//   register, before it shows on rsp_valid.
// Throughput: one word per cycle while not stalled (fully unrolled 32-stage rounds).
// Reset: synchronous, clears all valid bits, the keys and the direction (encrypt).
`timescale 1ns / 1ps

module gost_block_cipher_ecb_top (
   input  logic                          clock,
   input  logic                          reset,
   // input word channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [gost_pkg::BLOCK_W-1:0]  req_block_in,
   // result word channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gost_pkg::BLOCK_W-1:0]  rsp_block_out,
   // configuration writes
   input  logic                          csr_we,
   input  logic [gost_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [gost_pkg::BLOCK_W-1:0]  csr_data
);
   import gost_pkg::*;

   rkey_array_type rkeys;
   stage_type      stage [0:NUM_ROUNDS];
   logic           en;

   logic               out_valid_ff, out_valid_in;
   logic [BLOCK_W-1:0] out_data_ff,  out_data_in;
   logic               skid_valid_ff, skid_valid_in;
   logic [BLOCK_W-1:0] skid_data_ff,  skid_data_in;
   logic               pop;
   logic               incoming;
   logic [BLOCK_W-1:0] final_block;

   gost_key_sched u_key_sched (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rkeys     (rkeys)
   );

   // The whole round pipeline moves together; it only freezes while the
   // skid register holds a word, so the stall is a plain flop (no ripple).
   assign en        = ~skid_valid_ff;
   assign req_stall = skid_valid_ff;

   assign stage[0].valid = req_valid;
   assign stage[0].block = req_block_in;

   for (genvar k = 0; k < NUM_ROUNDS; k++) begin : g_round
      gost_round u_round (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .stage_in  (stage[k]),
         .rkey      (rkeys[k]),
         .stage_out (stage[k+1])
      );
   end

   // last round's halves swap once more
   assign final_block = {stage[NUM_ROUNDS].block[WORD_W-1:0],
                         stage[NUM_ROUNDS].block[BLOCK_W-1:WORD_W]};

   assign pop      = out_valid_ff & ~rsp_stall;
   assign incoming = en & stage[NUM_ROUNDS].valid;

   // Output register plus one skid entry. A word leaving the pipeline while
   // the output is held parks in the skid; the skid refills the output
   // once the sink takes the held word.
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (out_valid_ff && !pop) begin
         if (incoming) begin
            skid_valid_in = 1'b1;
            skid_data_in  = final_block;
         end
      end else begin
         out_valid_in = incoming;
         out_data_in  = final_block;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_block_out = out_data_ff;

   // skid only ever holds a word behind a held output word
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a word while output register is empty");

   // skid fills only when the output word was held by the sink
   a_skid_fill_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid filled without a held output word");

   // a drained skid leaves its word in the output register
   a_skid_drain: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_stall) |=> (out_valid_ff && !skid_valid_ff))
      else $error("skid drain lost a word");

   // frozen pipeline keeps its last stage
   a_freeze_holds: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(stage[NUM_ROUNDS].valid))
      else $error("round pipeline moved while frozen");

endmodule

>>> tb/tb_top.sv
// Self-checking testbench for the GOST 28147-89 ECB cipher top level.
`timescale 1ns / 1ps

module tb_top;

   localparam int unsigned CYCLE_LIMIT = 400_000;
   // the pipeline is 32 rounds deep; the extra slack catches stray results
   localparam int unsigned PIPE_SLACK  = 40;
   localparam int unsigned PHASE_SLACK = 4;
   localparam int unsigned RAND_PHASES = 20;
   localparam int unsigned PHASE_WORDS = 100;
   localparam int unsigned HOLD_CYCLES = 300;
   localparam int unsigned HOLD_PHASE  = 5;

   // first register index that decodes to nothing
   localparam logic [gost_pkg::CSR_IDX_W-1:0] CSR_FIRST_UNUSED =
      gost_pkg::CSR_DIRECTION + 1'b1;

   // key word picked by each round in encrypt order, zero based
   localparam logic [2:0] KEY_ORDER [32] = '{
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7,
      3'd7, 3'd6, 3'd5, 3'd4, 3'd3, 3'd2, 3'd1, 3'd0
   };

   // S1 .. S8; nibble i of the round sum goes through row 7-i
   localparam logic [3:0] SUBST_BOX [8][16] = '{
      '{4'd4, 4'd10, 4'd9, 4'd2, 4'd13, 4'd8, 4'd0, 4'd14,
        4'd6, 4'd11, 4'd1, 4'd12, 4'd7, 4'd15, 4'd5, 4'd3},
      '{4'd14, 4'd11, 4'd4, 4'd12, 4'd6, 4'd13, 4'd15, 4'd10,
        4'd2, 4'd3, 4'd8, 4'd1, 4'd0, 4'd7, 4'd5, 4'd9},
      '{4'd5, 4'd8, 4'd1, 4'd13, 4'd10, 4'd3, 4'd4, 4'd2,
        4'd14, 4'd15, 4'd12, 4'd7, 4'd6, 4'd0, 4'd9, 4'd11},
      '{4'd7, 4'd13, 4'd10, 4'd1, 4'd0, 4'd8, 4'd9, 4'd15,
        4'd14, 4'd4, 4'd6, 4'd12, 4'd11, 4'd2, 4'd5, 4'd3},
      '{4'd6, 4'd12, 4'd7, 4'd1, 4'd5, 4'd15, 4'd13, 4'd8,
        4'd4, 4'd10, 4'd9, 4'd14, 4'd0, 4'd3, 4'd11, 4'd2},
      '{4'd4, 4'd11, 4'd10, 4'd0, 4'd7, 4'd2, 4'd1, 4'd13,
        4'd3, 4'd6, 4'd8, 4'd5, 4'd9, 4'd12, 4'd15, 4'd14},
      '{4'd13, 4'd11, 4'd4, 4'd1, 4'd3, 4'd15, 4'd5, 4'd9,
        4'd0, 4'd10, 4'd14, 4'd7, 4'd6, 4'd8, 4'd2, 4'd12},
      '{4'd1, 4'd15, 4'd13, 4'd0, 4'd5, 4'd7, 4'd10, 4'd4,
        4'd9, 4'd2, 4'd3, 4'd14, 4'd6, 4'd11, 4'd8, 4'd12}
   };

   // Holds a mirror of the key and direction registers, predicts each
   // enciphered block and matches results in order against it.
   class gost_ecb_scoreboard;
      logic [31:0] key_word [8];
      logic        decrypt;
      logic [gost_pkg::BLOCK_W-1:0] expected_blocks [$];
      int unsigned error_count;
      int unsigned checked_count;

      function new();
         foreach (key_word[i]) key_word[i] = '0;
         decrypt       = 1'b0;
         error_count   = 0;
         checked_count = 0;
      endfunction

      // mirror of a csr write; unknown indexes are dropped, direction keeps bit 0
      function void set_register(logic [gost_pkg::CSR_IDX_W-1:0] idx,
                                 logic [gost_pkg::BLOCK_W-1:0] data);
         case (idx)
            gost_pkg::CSR_KEY_01: begin
               key_word[0] = data[31:0];
               key_word[1] = data[63:32];
            end
            gost_pkg::CSR_KEY_23: begin
               key_word[2] = data[31:0];
               key_word[3] = data[63:32];
            end
            gost_pkg::CSR_KEY_45: begin
               key_word[4] = data[31:0];
               key_word[5] = data[63:32];
            end
            gost_pkg::CSR_KEY_67: begin
               key_word[6] = data[31:0];
               key_word[7] = data[63:32];
            end
            gost_pkg::CSR_DIRECTION: begin
               decrypt = data[0];
            end
            default: begin
            end
         endcase
      endfunction

      // key add mod 2^32, nibble substitution, rotate left 11
      function logic [31:0] feistel_mix(logic [31:0] half, logic [31:0] rkey);
         logic [31:0] sum;
         logic [31:0] subst;
         sum = half + rkey;
         for (int i = 0; i < 8; i++) begin
            subst[4*i +: 4] = SUBST_BOX[7-i][sum[4*i +: 4]];
         end
         return {subst[20:0], subst[31:21]};
      endfunction

      function logic [gost_pkg::BLOCK_W-1:0] encipher_block(
         logic [gost_pkg::BLOCK_W-1:0] blk);
         logic [31:0] left;
         logic [31:0] right;
         logic [31:0] next_right;
         logic [4:0]  pos;
         left  = blk[63:32];
         right = blk[31:0];
         for (int r = 0; r < 32; r++) begin
            pos        = decrypt ? 5'(31 - r) : 5'(r);
            next_right = left ^ feistel_mix(right, key_word[KEY_ORDER[pos]]);
            left       = right;
            right      = next_right;
         end
         return {right, left};
      endfunction

      function void note_block_in(logic [gost_pkg::BLOCK_W-1:0] blk);
         expected_blocks.push_back(encipher_block(blk));
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t: %s", $time, msg);
         error_count++;
      endtask

      task check_block_out(logic [gost_pkg::BLOCK_W-1:0] got);
         logic [gost_pkg::BLOCK_W-1:0] want;
         if (expected_blocks.size() == 0) begin
            report_mismatch($sformatf("block_out %h with nothing pending", got));
         end else begin
            want = expected_blocks.pop_front();
            checked_count++;
            if (got !== want) begin
               report_mismatch($sformatf("block_out got %h want %h", got, want));
            end
         end
      endtask
   endclass

   // DUT-facing signals; every input starts at a known value
   logic                             clock        = 1'b0;
   logic                             reset        = 1'b1;
   logic                             req_valid    = 1'b0;
   logic                             req_stall;
   logic [gost_pkg::BLOCK_W-1:0]     req_block_in = '0;
   logic                             rsp_valid;
   logic                             rsp_stall    = 1'b0;
   logic [gost_pkg::BLOCK_W-1:0]     rsp_block_out;
   logic                             csr_we       = 1'b0;
   logic [gost_pkg::CSR_IDX_W-1:0]   csr_index    = '0;
   logic [gost_pkg::BLOCK_W-1:0]     csr_data     = '0;

   gost_ecb_scoreboard cipher_sb = new();

   int unsigned cycle_count       = 0;
   int unsigned blocks_sent       = 0;
   int unsigned settings_count    = 0;
   // largest idle gap either side draws per word; 0 gives back-to-back stretches
   int unsigned idle_max          = 11;
   // set by the stimulus; the result side picks it up and holds stall that long
   int unsigned hold_off_request  = 0;

   gost_block_cipher_ecb_top dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_block_in  (req_block_in),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_block_out (rsp_block_out),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_data      (csr_data)
   );

   always #5 clock = ~clock;

   // Watchdog: a hung handshake or a lost result ends the run here.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TIMEOUT after %0d cycles, %0d results still pending",
               cycle_count, cipher_sb.expected_blocks.size());
      $display("Some tests failed");
      $finish;
   end

   // Result side: random stall before each word, plus the long hold-off on
   // request. Outputs are sampled right after the edge, i.e. their pre-edge
   // values, so acceptance is valid high with stall low at that edge.
   // Sampling starts once reset is released, when rsp_valid is known.
   initial begin
      int unsigned gap;
      while (reset) @(posedge clock);
      forever begin
         if (hold_off_request > 0) begin
            gap = hold_off_request;
            hold_off_request = 0;
         end else begin
            gap = $urandom_range(0, idle_max);
         end
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         cipher_sb.check_block_out(rsp_block_out);
      end
   end

   // One register write; the enable stays up so writes can go back to back.
   // The caller drops csr_we after the last one.
   task csr_write(input logic [gost_pkg::CSR_IDX_W-1:0] idx,
                  input logic [gost_pkg::BLOCK_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      cipher_sb.set_register(idx, data);
   endtask

   // Full key plus direction. Direction data carries junk above bit 0, and
   // every call also hits one of the undecoded indexes, rotating through them.
   task apply_settings(input logic [255:0] key_bits, input logic decrypt_dir);
      logic [gost_pkg::CSR_IDX_W-1:0] unused_idx;
      unused_idx = CSR_FIRST_UNUSED + gost_pkg::CSR_IDX_W'(
                   settings_count % ((1 << gost_pkg::CSR_IDX_W) - CSR_FIRST_UNUSED));
      csr_write(gost_pkg::CSR_KEY_01, key_bits[63:0]);
      csr_write(gost_pkg::CSR_KEY_23, key_bits[127:64]);
      csr_write(gost_pkg::CSR_KEY_45, key_bits[191:128]);
      csr_write(gost_pkg::CSR_KEY_67, key_bits[255:192]);
      csr_write(unused_idx, {$urandom, $urandom});
      csr_write(gost_pkg::CSR_DIRECTION, {$urandom, $urandom_range(0, 1) ? 32'hffff_fffe
                                                          : 32'h0000_0000} | decrypt_dir);
      csr_we <= 1'b0;
      @(posedge clock);
      settings_count++;
   endtask

   // Offer one word after a random idle gap; valid stays up between
   // back-to-back words, so it is only lowered when a gap is drawn.
   task send_block(input logic [gost_pkg::BLOCK_W-1:0] blk);
      int unsigned gap;
      gap = $urandom_range(0, idle_max);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_block_in <= blk;
      do @(posedge clock); while (req_stall);
      cipher_sb.note_block_in(blk);
      blocks_sent++;
   endtask

   // Every word yields one result, so an empty queue means the pipe is empty.
   task wait_drained(input int unsigned slack);
      req_valid <= 1'b0;
      while (cipher_sb.expected_blocks.size() > 0) @(posedge clock);
      repeat (slack) @(posedge clock);
   endtask

   // Mostly random blocks, with a share of corner patterns.
   function logic [gost_pkg::BLOCK_W-1:0] pick_block();
      logic [gost_pkg::BLOCK_W-1:0] one_hot;
      one_hot = 64'd1 << $urandom_range(0, 63);
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return one_hot;
         3:       return ~one_hot;
         4:       return {$urandom, 32'h0000_0000};
         5:       return {32'hffff_ffff, $urandom};
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function logic [255:0] pick_key();
      logic [255:0] k;
      case ($urandom_range(0, 7))
         0:       k = '0;
         1:       k = '1;
         default: begin
            for (int i = 0; i < 8; i++) k[32*i +: 32] = $urandom;
         end
      endcase
      return k;
   endfunction

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: reset key (all zero), encrypt, extreme blocks.
      idle_max = 11;
      send_block(64'h0000_0000_0000_0000);
      send_block(64'hffff_ffff_ffff_ffff);
      send_block(64'h0000_0000_0000_0001);
      send_block(64'h8000_0000_0000_0000);
      wait_drained(PHASE_SLACK);

      // Directed: all-ones key, so every round sum with a nonzero half carries out of 32 bits.
      apply_settings('1, 1'b0);
      send_block(64'h0000_0000_0000_0000);
      send_block(64'hffff_ffff_ffff_ffff);
      send_block(64'h0123_4567_89ab_cdef);
      send_block(64'hfedc_ba98_7654_3210);
      wait_drained(PHASE_SLACK);

      // Directed: distinct key words, decrypt, back-to-back words.
      idle_max = 0;
      apply_settings({32'h0807_0605, 32'h0403_0201, 32'hdead_beef, 32'h1234_5678,
                      32'h8000_0000, 32'h7fff_ffff, 32'h0000_0001, 32'hffff_fffe}, 1'b1);
      send_block(64'h0000_0000_0000_0000);
      send_block(64'hffff_ffff_ffff_ffff);
      send_block(64'h5555_5555_aaaa_aaaa);
      send_block(64'haaaa_aaaa_5555_5555);
      send_block(64'h0000_0001_8000_0000);
      send_block(64'h7fff_ffff_ffff_fffe);
      wait_drained(PHASE_SLACK);

      // Random phases: new key and direction each time, idling on most,
      // one phase with a long output hold-off while input keeps coming.
      for (int unsigned phase = 0; phase < RAND_PHASES; phase++) begin
         apply_settings(pick_key(), 1'($urandom_range(0, 1)));
         idle_max = (phase % 3 == 2) ? 0 : 11;
         if (phase == HOLD_PHASE) begin
            idle_max = 0;
            hold_off_request = HOLD_CYCLES;
         end
         for (int unsigned n = 0; n < PHASE_WORDS; n++) begin
            send_block(pick_block());
         end
         wait_drained(PHASE_SLACK);
      end

      wait_drained(PIPE_SLACK);

      $display("Covered %0d blocks under %0d key/direction settings plus reset keys,",
               blocks_sent, settings_count);
      $display("both directions, random idle gaps and a %0d-cycle output hold-off.",
               HOLD_CYCLES);
      if (cipher_sb.error_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("%0d mismatches in %0d checked results",
                  cipher_sb.error_count, cipher_sb.checked_count);
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

>>> gost_block_cipher_ecb_top.f
rtl/core/gost_pkg.sv
rtl/core/gost_key_sched.sv
rtl/core/gost_round.sv
rtl/core/gost_block_cipher_ecb_top.sv
tb/tb_top.sv
